/* hw/rtl/ppp_pkg.sv */
// Types, constants and widths shared by the projection pipeline.
package ppp_pkg;

    localparam int COORD_W = 32;
    localparam int SUM_W   = 68;
    localparam int MAG_W   = 67;
    localparam int QUO_W   = 33;
    localparam int NUM_REGS = 6;
    localparam int IDX_W   = 3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_u;
        logic signed [COORD_W-1:0] pixel_v;
        logic [1:0]                status;
    } pixel_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             neg_u;
        logic             neg_v;
        logic [MAG_W-1:0] num_u;
        logic [MAG_W-1:0] num_v;
        logic [MAG_W-1:0] den;
        logic [MAG_W-1:0] rem_u;
        logic [MAG_W-1:0] rem_v;
        logic [QUO_W-1:0] quo_u;
        logic [QUO_W-1:0] quo_v;
        logic             big_u;
        logic             big_v;
    } div_lane_t;

endpackage

/* hw/rtl/ppp_div_cell.sv */
// One restoring-division cell: retires one quotient bit for both coordinates.
module ppp_div_cell #(
    parameter int BIT = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  ppp_pkg::div_lane_t lane_in,
    output ppp_pkg::div_lane_t lane_out
);
    import ppp_pkg::*;

    div_lane_t lane_reg;
    div_lane_t lane_next;

    logic [MAG_W:0] tu;
    logic [MAG_W:0] tv;

    always_comb
    begin
        lane_next = lane_in;
        tu = {lane_in.rem_u, lane_in.num_u[BIT]};
        tv = {lane_in.rem_v, lane_in.num_v[BIT]};
        if (tu >= {1'b0, lane_in.den})
        begin
            tu = tu - {1'b0, lane_in.den};
            if (BIT >= QUO_W - 1)
                lane_next.big_u = 1'b1;
            else
                lane_next.quo_u[BIT % QUO_W] = 1'b1;
        end
        if (tv >= {1'b0, lane_in.den})
        begin
            tv = tv - {1'b0, lane_in.den};
            if (BIT >= QUO_W - 1)
                lane_next.big_v = 1'b1;
            else
                lane_next.quo_v[BIT % QUO_W] = 1'b1;
        end
        lane_next.rem_u = tu[MAG_W-1:0];
        lane_next.rem_v = tv[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;
endmodule

/* hw/rtl/ppp_row_sums.sv */
// Matrix-vector front end: products, row sums and divider operand setup.
module ppp_row_sums (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   in_valid,
    input  ppp_pkg::point_t        point,
    input  logic [4*64-1:0]        row0,
    input  logic [4*64-1:0]        row1,
    input  logic [4*64-1:0]        row2,
    input  logic [5:0]             frac_bits,
    output ppp_pkg::div_lane_t     lane_out
);
    import ppp_pkg::*;

    logic                     v1_reg;
    logic signed [63:0]       p_reg [3][3];
    logic signed [SUM_W-1:0]  c_reg [3];
    logic                     v2_reg;
    logic signed [SUM_W-1:0]  s_reg [3];
    div_lane_t                lane_reg;
    div_lane_t                lane_next;

    function automatic logic signed [31:0] coef(input logic [4*64-1:0] r, input int c);
        coef = r[c*32 +: 32];
    endfunction

    function automatic logic [4*64-1:0] row_of(input int r, input logic [4*64-1:0] a,
                                              input logic [4*64-1:0] b,
                                              input logic [4*64-1:0] d);
        row_of = (r == 0) ? a : ((r == 1) ? b : d);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r < 3; r++)
            begin
                p_reg[r][0] <= 64'(coef(row_of(r, row0, row1, row2), 0)) * 64'(point.point_x);
                p_reg[r][1] <= 64'(coef(row_of(r, row0, row1, row2), 1)) * 64'(point.point_y);
                p_reg[r][2] <= 64'(coef(row_of(r, row0, row1, row2), 2)) * 64'(point.point_z);
                c_reg[r] <= SUM_W'(coef(row_of(r, row0, row1, row2), 3)) <<< frac_bits;
                s_reg[r] <= SUM_W'(p_reg[r][0]) + SUM_W'(p_reg[r][1])
                          + SUM_W'(p_reg[r][2]) + c_reg[r];
            end
        end
    end

    function automatic logic [MAG_W-1:0] mag(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = s[SUM_W-1] ? -s : s;
        mag = t[MAG_W-1:0];
    endfunction

    always_comb
    begin
        lane_next = '0;
        lane_next.valid = v2_reg;
        lane_next.zero  = (s_reg[2] == '0);
        lane_next.neg_u = s_reg[0][SUM_W-1] ^ s_reg[2][SUM_W-1];
        lane_next.neg_v = s_reg[1][SUM_W-1] ^ s_reg[2][SUM_W-1];
        lane_next.num_u = mag(s_reg[0]);
        lane_next.num_v = mag(s_reg[1]);
        lane_next.den   = lane_next.zero ? MAG_W'(1) : mag(s_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;
endmodule

/* hw/rtl/perspective_point_projection.sv */
// Top level: pinhole projection pipeline with a chain of division cells.
//  channel | handshake        | payload
//  point   | point_valid/stall| point (x, y, z)
//  pixel   | pixel_valid/stall| pixel (u, v, status)
//  cfg     | cfg_valid/ready  | cfg_index, cfg_data
// One point per cycle while pixel_stall is low; the divider chain has one cell per quotient bit.
// Reset clears the matrix and all valid flags.
// A stall on the result freezes the whole pipeline; point_stall follows pixel_stall.
module perspective_point_projection #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_stall,
    input  ppp_pkg::point_t  point,
    output logic             pixel_valid,
    input  logic             pixel_stall,
    output ppp_pkg::pixel_t  pixel,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data
);
    import ppp_pkg::*;

    logic [63:0] regs_reg [NUM_REGS];
    logic        advance;
    div_lane_t   chain [MAG_W+1];
    pixel_t      pix_reg;
    pixel_t      pix_next;
    logic        pv_reg;

    assign cfg_ready = 1'b1;
    assign advance = !(pv_reg && pixel_stall);
    assign point_stall = pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                regs_reg[i] <= '0;
        end
        else if (cfg_valid && int'(cfg_index) < NUM_REGS)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    ppp_row_sums u_sums (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (point_valid && !point_stall),
        .point     (point),
        .row0      ({regs_reg[1], regs_reg[0]}),
        .row1      ({regs_reg[3], regs_reg[2]}),
        .row2      ({regs_reg[5], regs_reg[4]}),
        .frac_bits (6'(COORD_FRAC_BITS)),
        .lane_out  (chain[0])
    );

    for (genvar g = 0; g < MAG_W; g++)
    begin : g_cell
        ppp_div_cell #(.BIT(MAG_W - 1 - g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .lane_in  (chain[g]),
            .lane_out (chain[g+1])
        );
    end

    always_comb
    begin
        div_lane_t l;
        logic su;
        logic sv;
        l = chain[MAG_W];
        su = l.big_u || (l.neg_u ? (l.quo_u > 33'h080000000) : (l.quo_u > 33'h07FFFFFFF));
        sv = l.big_v || (l.neg_v ? (l.quo_v > 33'h080000000) : (l.quo_v > 33'h07FFFFFFF));
        pix_next.pixel_u = su ? (l.neg_u ? 32'sh80000000 : 32'sh7FFFFFFF)
                              : (l.neg_u ? -l.quo_u[31:0] : l.quo_u[31:0]);
        pix_next.pixel_v = sv ? (l.neg_v ? 32'sh80000000 : 32'sh7FFFFFFF)
                              : (l.neg_v ? -l.quo_v[31:0] : l.quo_v[31:0]);
        pix_next.status = (su || sv) ? ST_SAT : ST_OK;
        if (l.zero)
        begin
            pix_next.pixel_u = '0;
            pix_next.pixel_v = '0;
            pix_next.status  = ST_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (advance)
            pv_reg <= chain[MAG_W].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            pix_reg <= pix_next;
    end

    assign pixel_valid = pv_reg;
    assign pixel = pix_reg;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
        else $error("result changed under stall");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel.status == ST_ZERO |-> pixel.pixel_u == '0 && pixel.pixel_v == '0)
        else $error("zero divisor result not cleared");
`endif
endmodule

/* tb/tb_top.sv */
// Testbench for the pinhole projection block: directed and random points, matrix settings, idle and stall phases.
`timescale 1ns / 100ps

module tb_top;
    import ppp_pkg::*;

    localparam int LATENCY = 71;
    localparam int COORD_FRAC_BITS = 16;

    typedef enum logic [2:0] {
        R0C01 = 3'd0, R0C23 = 3'd1, R1C01 = 3'd2, R1C23 = 3'd3,
        R2C01 = 3'd4, R2C23 = 3'd5, RNONE = 3'd6
    } reg_idx_e;

    logic        clk;
    logic        rst_n;
    logic        point_valid;
    logic        point_stall;
    point_t      point;
    logic        pixel_valid;
    logic        pixel_stall;
    pixel_t      pixel;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    perspective_point_projection dut (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_stall(point_stall), .point(point),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [63:0] matrix_regs [NUM_REGS];
    point_t      pending_points [$];
    pixel_t      expected_pixels [$];
    int          send_idle_pct;
    int          stall_pct;
    int          errors;
    bit          cfg_done;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic signed [127:0] row_total(int row, point_t p);
        logic signed [127:0] s;
        logic signed [31:0]  c [4];
        for (int k = 0; k < 4; k++)
            c[k] = matrix_regs[row*2 + k/2][32*(k%2) +: 32];
        s = 128'(c[0]) * 128'(p.point_x) + 128'(c[1]) * 128'(p.point_y)
            + 128'(c[2]) * 128'(p.point_z) + (128'(c[3]) <<< COORD_FRAC_BITS);
        return s;
    endfunction

    function automatic logic signed [31:0] clamp_quotient(logic signed [127:0] n,
                                                          logic signed [127:0] d,
                                                          ref bit sat);
        logic signed [127:0] q;
        q = n / d;
        if (q > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    function automatic pixel_t project_point(point_t p);
        pixel_t r;
        logic signed [127:0] s0, s1, s2;
        bit sat;
        s0 = row_total(0, p);
        s1 = row_total(1, p);
        s2 = row_total(2, p);
        sat = 1'b0;
        if (s2 == 0)
        begin
            r.pixel_u = '0;
            r.pixel_v = '0;
            r.status = ST_ZERO;
            return r;
        end
        r.pixel_u = clamp_quotient(s0, s2, sat);
        r.pixel_v = clamp_quotient(s1, s2, sat);
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_valid <= 1'b0;
            point <= '0;
        end
        else if (!point_valid || !point_stall)
        begin
            if (point_valid)
                expected_pixels.push_back(project_point(point));
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                point_valid <= 1'b1;
                point <= pending_points.pop_front();
            end
            else
                point_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pixel_stall <= 1'b0;
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected pixel u=%0d v=%0d", pixel.pixel_u, pixel.pixel_v);
                    errors++;
                end
                else
                begin
                    pixel_t e;
                    e = expected_pixels.pop_front();
                    if (pixel.pixel_u !== e.pixel_u)
                    begin
                        $error("pixel_u expected %0d actual %0d", e.pixel_u, pixel.pixel_u);
                        errors++;
                    end
                    if (pixel.pixel_v !== e.pixel_v)
                    begin
                        $error("pixel_v expected %0d actual %0d", e.pixel_v, pixel.pixel_v);
                        errors++;
                    end
                    if (pixel.status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, pixel.status);
                        errors++;
                    end
                end
            end
            pixel_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(reg_idx_e idx, logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_done = 1'b0;
        while (!cfg_done)
        begin
            @(posedge clk);
            cfg_done = cfg_ready;
        end
        cfg_valid <= 1'b0;
        if (idx != RNONE)
            matrix_regs[idx] = val;
    endtask

    task automatic drain_pipeline();
        while (pending_points.size() > 0 || point_valid || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(2047)) - 1024) <<< 16;
            2: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
            default: return 32'($signed($urandom_range(255)) - 128) <<< 14;
        endcase
    endfunction

    task automatic queue_random(int n);
        point_t p;
        int mode;
        for (int i = 0; i < n; i++)
        begin
            mode = $urandom_range(3);
            p.point_x = rand_coord(mode);
            p.point_y = rand_coord(mode);
            p.point_z = ($urandom_range(19) == 0) ? 32'sd0 : rand_coord(mode);
            pending_points.push_back(p);
        end
    endtask

    task automatic load_camera(int mode);
        logic [31:0] c [12];
        for (int k = 0; k < 12; k++)
            c[k] = rand_coord(mode);
        if (mode == 3)
        begin
            c[8] = '0;
            c[9] = '0;
            c[10] = '0;
        end
        for (int r = 0; r < 6; r++)
            write_reg(reg_idx_e'(r), {c[2*r+1], c[2*r]});
    endtask

    initial
    begin
        point_t p;
        errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int r = 0; r < NUM_REGS; r++)
            matrix_regs[r] = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // all-zero matrix: zero divisor
        p = '{32'sd65536, 32'sd0, 32'sd0};
        pending_points.push_back(p);
        drain_pipeline();

        write_reg(R0C01, {32'sh00000000, 32'sh00010000});
        write_reg(R0C23, {32'sh00000000, 32'sh00000000});
        write_reg(R1C01, {32'sh00010000, 32'sh00000000});
        write_reg(R1C23, {32'sh00000000, 32'sh00000000});
        write_reg(R2C01, 64'h0);
        write_reg(R2C23, {32'sh00000000, 32'sh00010000});
        write_reg(RNONE, 64'hffffffffffffffff);
        pending_points.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh00010000});
        pending_points.push_back('{32'sh80000000, 32'sh7fffffff, 32'shffff0000});
        pending_points.push_back('{32'sh00100000, 32'shfff00000, 32'sh00000001});
        pending_points.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
        pending_points.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000});
        pending_points.push_back('{32'sh00000000, 32'sh00000000, 32'sh00000000});
        pending_points.push_back('{32'shffffffff, 32'sh00000001, 32'sh00000002});
        pending_points.push_back('{32'sh00050000, 32'shfffb0000, 32'shfffe0000});
        drain_pipeline();

        write_reg(R0C01, 64'h7fffffff80000000);
        write_reg(R0C23, 64'h800000007fffffff);
        write_reg(R1C01, 64'h80000000ffffffff);
        write_reg(R1C23, 64'h7fffffff00000001);
        write_reg(R2C01, 64'h0000000100000000);
        write_reg(R2C23, 64'h8000000000000001);
        pending_points.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
        pending_points.push_back('{32'sh80000000, 32'sh7fffffff, 32'sh80000000});
        pending_points.push_back('{32'sh00000000, 32'sh00000000, 32'sh00000000});
        pending_points.push_back('{32'sh00000001, 32'shffffffff, 32'sh00000001});
        drain_pipeline();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 46; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 46; end
                default: begin send_idle_pct = 7; stall_pct = 7; end
            endcase
            load_camera(ph % 4);
            queue_random(108);
            drain_pipeline();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/ppp_pkg.sv
hw/rtl/ppp_div_cell.sv
hw/rtl/ppp_row_sums.sv
hw/rtl/perspective_point_projection.sv
tb/tb_top.sv
